// ===== src/sik_pkg.sv =====
package sik_pkg;

  localparam int DEF_CORDIC_ITERATIONS = 16;
  localparam int DEF_COORD_WIDTH = 15;

  // Datapath widths.
  localparam int XW = 34;
  localparam int AW = 32;
  localparam int ANG_W = 15;
  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 25;
  localparam int SQRT_STEPS = 25;
  localparam int SQ_W = 50;
  localparam int SQ_TOP = 2 * (SQRT_STEPS - 1);
  localparam int DEG_W = AW + 6;
  localparam int DEG_SHIFT = 23;

  localparam logic [AW-1:0] INV_GAIN = 32'd2608131496;
  localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [ANG_W-1:0] DEG_HALF = 15'd11520;
  localparam logic [DEG_W-1:0] DEG_SCALE = 38'd45;
  localparam logic [DEG_W-1:0] DEG_ROUND = 38'h40_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_LINK1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELBOW = 2'd3;

  localparam logic [CFG_W-1:0] RST_LINK1 = 14'd5600;
  localparam logic [CFG_W-1:0] RST_LINK2 = 14'd4000;
  localparam logic [CFG_W-1:0] RST_SHOULDER = 14'd9600;
  localparam logic [CFG_W-1:0] RST_ELBOW = 14'd10880;

  localparam logic [1:0] ARM_LEFT = 2'd0;
  localparam logic [1:0] ARM_RIGHT = 2'd1;

  // Arctangent of 2^-k as a binary angle, 2^32 units per turn.
  function automatic logic [AW-1:0] atan_at(input logic [4:0] k);
    logic [AW-1:0] a;
    unique case (k)
      5'd0: a = 32'd536870912;
      5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;
      5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;
      5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;
      5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;
      5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      5'd31: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/scara_inverse_kinematics.sv =====
// Throughput: one word per cycle; every stage is a register of a single pipeline,
// and the whole pipeline holds while the output word is not taken.
// Reset (synchronous, active low) clears all valid bits and loads the default
// link lengths and joint limits.
module scara_inverse_kinematics
  import sik_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_tool_x,
  input  logic signed [COORD_WIDTH-1:0] in_tool_y,
  input  logic [1:0]                    in_arm_select,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ANG_W-1:0]       out_theta1,
  output logic signed [ANG_W-1:0]       out_theta2,
  output logic                          out_in_range
);

  localparam int CW = COORD_WIDTH;
  localparam int ITER = CORDIC_ITERATIONS;
  localparam int FRAC = 31 - COORD_WIDTH;
  localparam int NW = ((2 * CW > 2 * CFG_W) ? 2 * CW : 2 * CFG_W) + 2;
  localparam int DW = ((NW - 1 + FRAC > 47) ? NW - 1 + FRAC : 47);
  localparam int QW = DIV_STEPS;
  localparam int S1W = 2 + 2 * CW;
  localparam int DSBW = 3 + AW + 2 * CW;
  localparam int SSBW = DSBW + QW;
  localparam int S2W = 2 + AW + 2 * CW;
  localparam int S3W = 1 + AW + 2 * CW;
  localparam int S4W = 2 + AW;
  localparam int SPW = CFG_W + AW;

  logic en;

  // Configuration registers.
  logic [CFG_W-1:0] link1_r, link2_r, shoulder_lim_r, elbow_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_r        <= RST_LINK1;
      link2_r        <= RST_LINK2;
      shoulder_lim_r <= RST_SHOULDER;
      elbow_lim_r    <= RST_ELBOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINK1:    link1_r        <= cfg_data;
        CFG_LINK2:    link2_r        <= cfg_data;
        CFG_SHOULDER: shoulder_lim_r <= cfg_data;
        CFG_ELBOW:    elbow_lim_r    <= cfg_data;
      endcase
    end
  end

  logic out_valid_r;

  // One enable for the whole pipeline: it moves whenever the output word
  // is free or being taken.
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  // Input stage.
  logic                 v_a_r;
  logic signed [CW-1:0] x_a_r, y_a_r;
  logic [1:0]           arm_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r   <= in_tool_x;
      y_a_r   <= in_tool_y;
      arm_a_r <= in_arm_select;
    end
  end

  logic                 ok_a;
  logic signed [XW-1:0] xs_a, ys_a;

  assign ok_a = (arm_a_r == ARM_LEFT || arm_a_r == ARM_RIGHT) &&
                (x_a_r != '0 || y_a_r != '0);
  assign xs_a = XW'(x_a_r) <<< FRAC;
  assign ys_a = XW'(y_a_r) <<< FRAC;

  // Direction and length of the tool point.
  logic                 c1_v;
  logic signed [XW-1:0] c1_x;
  logic [AW-1:0]        c1_z;
  logic [S1W-1:0]       c1_side;

  sik_cordic #(.ITER(ITER), .SIDE_W(S1W), .ROTATE(1'b0)) u_cordic_beta (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_a_r),
    .in_x     (xs_a),
    .in_y     (ys_a),
    .in_z     ('0),
    .in_side  ({ok_a, arm_a_r[0], x_a_r, y_a_r}),
    .out_valid(c1_v),
    .out_x    (c1_x),
    .out_y    (),
    .out_z    (c1_z),
    .out_side (c1_side)
  );

  logic                 ok1, arm1;
  logic signed [CW-1:0] x1, y1;

  assign {ok1, arm1, x1, y1} = c1_side;

  // P1: gain correction and squares.
  logic                 v_p1_r, ok_p1_r, arm_p1_r;
  logic [AW-1:0]        lq_p1_r, beta_p1_r;
  logic [2*CW-1:0]      xx_p1_r, yy_p1_r;
  logic [2*CFG_W-1:0]   l1sq_p1_r, l2sq_p1_r;
  logic signed [CW-1:0] x_p1_r, y_p1_r;
  logic [2*AW-1:0]      lq_full;

  assign lq_full = (2 * AW)'(c1_x[AW-1:0]) * (2 * AW)'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p1_r <= 1'b0;
    end else if (en) begin
      v_p1_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lq_p1_r   <= lq_full[2*AW-1:AW];
      xx_p1_r   <= (2 * CW)'(x1) * (2 * CW)'(x1);
      yy_p1_r   <= (2 * CW)'(y1) * (2 * CW)'(y1);
      l1sq_p1_r <= (2 * CFG_W)'(link1_r) * (2 * CFG_W)'(link1_r);
      l2sq_p1_r <= (2 * CFG_W)'(link2_r) * (2 * CFG_W)'(link2_r);
      beta_p1_r <= c1_z;
      ok_p1_r   <= ok1;
      arm_p1_r  <= arm1;
      x_p1_r    <= x1;
      y_p1_r    <= y1;
    end
  end

  // P2: law-of-cosines numerator and denominator.
  logic                 v_p2_r, ok_p2_r, arm_p2_r;
  logic signed [NW-1:0] num_p2_r;
  logic [DW-1:0]        den_p2_r;
  logic [AW-1:0]        beta_p2_r;
  logic signed [CW-1:0] x_p2_r, y_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p2_r <= 1'b0;
    end else if (en) begin
      v_p2_r <= v_p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_p2_r  <= $signed(NW'(xx_p1_r) + NW'(yy_p1_r) + NW'(l1sq_p1_r) - NW'(l2sq_p1_r));
      den_p2_r  <= (DW'(lq_p1_r) * DW'(link1_r)) << 1;
      beta_p2_r <= beta_p1_r;
      ok_p2_r   <= ok_p1_r;
      arm_p2_r  <= arm_p1_r;
      x_p2_r    <= x_p1_r;
      y_p2_r    <= y_p1_r;
    end
  end

  // P3: scaled magnitude of the numerator and the reach test.
  logic [NW-1:0] nabs;
  logic [DW-1:0] n_nxt;
  logic          reach_nxt;

  assign nabs      = num_p2_r[NW-1] ? NW'(-num_p2_r) : NW'(num_p2_r);
  assign n_nxt     = DW'(nabs) << FRAC;
  assign reach_nxt = ok_p2_r && den_p2_r != '0 && n_nxt <= den_p2_r;

  logic            v_p3_r;
  logic [DW-1:0]   n_p3_r, den_p3_r;
  logic [DSBW-1:0] sb_p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p3_r <= 1'b0;
    end else if (en) begin
      v_p3_r <= v_p2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_p3_r   <= n_nxt;
      den_p3_r <= den_p2_r;
      sb_p3_r  <= {reach_nxt, num_p2_r[NW-1], beta_p2_r, x_p2_r, y_p2_r, arm_p2_r};
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic            dv_r  [DIV_STEPS];
  logic [DW:0]     dr_r  [DIV_STEPS];
  logic [QW-1:0]   dq_r  [DIV_STEPS];
  logic [DW-1:0]   dd_r  [DIV_STEPS];
  logic [DSBW-1:0] dsb_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic            v_in;
    logic [DW:0]     r_sh, r_nxt;
    logic [QW-1:0]   q_in, q_nxt;
    logic [DW-1:0]   d_in;
    logic [DSBW-1:0] sb_in;

    if (j == 0) begin : g_first
      assign v_in  = v_p3_r;
      assign r_sh  = {1'b0, n_p3_r};
      assign q_in  = '0;
      assign d_in  = den_p3_r;
      assign sb_in = sb_p3_r;
    end else begin : g_next
      assign v_in  = dv_r[j-1];
      assign r_sh  = {dr_r[j-1][DW-1:0], 1'b0};
      assign q_in  = dq_r[j-1];
      assign d_in  = dd_r[j-1];
      assign sb_in = dsb_r[j-1];
    end

    always_comb begin
      r_nxt = r_sh;
      q_nxt = q_in << 1;
      if (r_sh >= {1'b0, d_in}) begin
        r_nxt    = r_sh - {1'b0, d_in};
        q_nxt[0] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[j]  <= r_nxt;
        dq_r[j]  <= q_nxt;
        dd_r[j]  <= d_in;
        dsb_r[j] <= sb_in;
      end
    end
  end

  // Q1: square of the cosine.
  logic            v_q1_r;
  logic [QW-1:0]   c_q1_r;
  logic [SQ_W-1:0] csq_q1_r;
  logic [DSBW-1:0] sb_q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_q1_r <= 1'b0;
    end else if (en) begin
      v_q1_r <= dv_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q1_r   <= dq_r[DIV_STEPS-1];
      csq_q1_r <= SQ_W'(dq_r[DIV_STEPS-1]) * SQ_W'(dq_r[DIV_STEPS-1]);
      sb_q1_r  <= dsb_r[DIV_STEPS-1];
    end
  end

  // Integer square root of one minus cosine squared, two radicand bits per stage.
  logic            sv_vr [SQRT_STEPS];
  logic [SQ_W-1:0] sv_r  [SQRT_STEPS];
  logic [SQ_W-1:0] sr_r  [SQRT_STEPS];
  logic [SSBW-1:0] ssb_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_TOP - 2 * j);
    logic            v_in;
    logic [SQ_W-1:0] rad_in, root_in, trial, rad_nxt, root_nxt;
    logic [SSBW-1:0] sb_in;

    if (j == 0) begin : g_first
      assign v_in    = v_q1_r;
      assign rad_in  = (SQ_W'(1) << SQ_TOP) - csq_q1_r;
      assign root_in = '0;
      assign sb_in   = {sb_q1_r, c_q1_r};
    end else begin : g_next
      assign v_in    = sv_vr[j-1];
      assign rad_in  = sv_r[j-1];
      assign root_in = sr_r[j-1];
      assign sb_in   = ssb_r[j-1];
    end

    assign trial = root_in + BIT;

    always_comb begin
      if (rad_in >= trial) begin
        rad_nxt  = rad_in - trial;
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rad_nxt  = rad_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_vr[j] <= 1'b0;
      end else if (en) begin
        sv_vr[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[j]  <= rad_nxt;
        sr_r[j]  <= root_nxt;
        ssb_r[j] <= sb_in;
      end
    end
  end

  logic                 reach4, neg4, arm4;
  logic [AW-1:0]        beta4;
  logic signed [CW-1:0] x4, y4;
  logic [QW-1:0]        c4, s4;
  logic signed [XW-1:0] cx4, sy4;

  assign {reach4, neg4, beta4, x4, y4, arm4, c4} = ssb_r[SQRT_STEPS-1];
  assign s4  = sr_r[SQRT_STEPS-1][QW-1:0];
  assign cx4 = neg4 ? -$signed(XW'(c4)) : $signed(XW'(c4));
  assign sy4 = $signed(XW'(s4));

  // Elbow offset angle alpha from (cos, sin).
  logic           c2_v;
  logic [AW-1:0]  c2_z;
  logic [S2W-1:0] c2_side;

  sik_cordic #(.ITER(ITER), .SIDE_W(S2W), .ROTATE(1'b0)) u_cordic_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sv_vr[SQRT_STEPS-1]),
    .in_x     (cx4),
    .in_y     (sy4),
    .in_z     ('0),
    .in_side  ({reach4, arm4, beta4, x4, y4}),
    .out_valid(c2_v),
    .out_x    (),
    .out_y    (),
    .out_z    (c2_z),
    .out_side (c2_side)
  );

  logic                 reach5, arm5;
  logic [AW-1:0]        beta5;
  logic signed [CW-1:0] x5, y5;
  logic [SPW-1:0]       start_prod;

  assign {reach5, arm5, beta5, x5, y5} = c2_side;
  assign start_prod = SPW'(link1_r) * SPW'(INV_GAIN);

  // R0: shoulder angle and gain-compensated first link vector.
  logic                 v_r0_r, reach_r0_r;
  logic [AW-1:0]        a1_r0_r;
  logic signed [XW-1:0] start_r0_r;
  logic signed [CW-1:0] x_r0_r, y_r0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r0_r <= 1'b0;
    end else if (en) begin
      v_r0_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r0_r    <= arm5 ? beta5 - c2_z : beta5 + c2_z;
      start_r0_r <= $signed(XW'(start_prod >> (AW - FRAC)));
      reach_r0_r <= reach5;
      x_r0_r     <= x5;
      y_r0_r     <= y5;
    end
  end

  // Elbow position by rotating the first link.
  logic                 c3_v;
  logic signed [XW-1:0] c3_x, c3_y;
  logic [S3W-1:0]       c3_side;

  sik_cordic #(.ITER(ITER), .SIDE_W(S3W), .ROTATE(1'b1)) u_cordic_elbow (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_r0_r),
    .in_x     (start_r0_r),
    .in_y     ('0),
    .in_z     (a1_r0_r),
    .in_side  ({reach_r0_r, a1_r0_r, x_r0_r, y_r0_r}),
    .out_valid(c3_v),
    .out_x    (c3_x),
    .out_y    (c3_y),
    .out_z    (),
    .out_side (c3_side)
  );

  logic                 reach6;
  logic [AW-1:0]        a1_6;
  logic signed [CW-1:0] x6, y6;
  logic signed [XW-1:0] rx_nxt, ry_nxt;

  assign {reach6, a1_6, x6, y6} = c3_side;
  assign rx_nxt = (XW'(x6) <<< FRAC) - c3_x;
  assign ry_nxt = (XW'(y6) <<< FRAC) - c3_y;

  // R1: elbow-to-tool vector.
  logic                 v_r1_r;
  logic signed [XW-1:0] rx_r1_r, ry_r1_r;
  logic [S4W-1:0]       sb_r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r1_r <= 1'b0;
    end else if (en) begin
      v_r1_r <= c3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r1_r <= rx_nxt;
      ry_r1_r <= ry_nxt;
      sb_r1_r <= {reach6, (rx_nxt == '0 && ry_nxt == '0), a1_6};
    end
  end

  logic           c4_v;
  logic [AW-1:0]  c4_z;
  logic [S4W-1:0] c4_side;

  sik_cordic #(.ITER(ITER), .SIDE_W(S4W), .ROTATE(1'b0)) u_cordic_phi (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_r1_r),
    .in_x     (rx_r1_r),
    .in_y     (ry_r1_r),
    .in_z     ('0),
    .in_side  (sb_r1_r),
    .out_valid(c4_v),
    .out_x    (),
    .out_y    (),
    .out_z    (c4_z),
    .out_side (c4_side)
  );

  logic          reach7, zero7;
  logic [AW-1:0] a1_7, phi7, t2_ang, m1, m2;

  assign {reach7, zero7, a1_7} = c4_side;
  // A zero elbow-to-tool vector has no direction; it counts as angle zero.
  assign phi7   = zero7 ? '0 : c4_z;
  assign t2_ang = phi7 - a1_7;
  assign m1     = a1_7[AW-1] ? -a1_7 : a1_7;
  assign m2     = t2_ang[AW-1] ? -t2_ang : t2_ang;

  // D1: scale binary angles to 1/64 degree, rounding half away from zero.
  logic             v_d1_r, reach_d1_r, neg1_d1_r, neg2_d1_r;
  logic [DEG_W-1:0] deg1_d1_r, deg2_d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d1_r <= 1'b0;
    end else if (en) begin
      v_d1_r <= c4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg1_d1_r  <= DEG_W'(m1) * DEG_SCALE + DEG_ROUND;
      deg2_d1_r  <= DEG_W'(m2) * DEG_SCALE + DEG_ROUND;
      neg1_d1_r  <= a1_7[AW-1];
      neg2_d1_r  <= t2_ang[AW-1];
      reach_d1_r <= reach7;
    end
  end

  logic [ANG_W-1:0] q1, q2, t1_nxt, t2_nxt;
  logic             in_range_nxt;

  assign q1 = deg1_d1_r[DEG_W-1:DEG_SHIFT];
  assign q2 = deg2_d1_r[DEG_W-1:DEG_SHIFT];
  // Minus half a turn is reported as plus half a turn.
  assign t1_nxt = (neg1_d1_r && q1 != DEG_HALF) ? -q1 : q1;
  assign t2_nxt = (neg2_d1_r && q2 != DEG_HALF) ? -q2 : q2;
  assign in_range_nxt = reach_d1_r && q1 <= ANG_W'(shoulder_lim_r) &&
                        q2 <= ANG_W'(elbow_lim_r);

  // Output register.
  logic signed [ANG_W-1:0] theta1_r, theta2_r;
  logic                    in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta1_r   <= reach_d1_r ? $signed(t1_nxt) : '0;
      theta2_r   <= reach_d1_r ? $signed(t2_nxt) : '0;
      in_range_r <= in_range_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_theta1   = theta1_r;
  assign out_theta2   = theta2_r;
  assign out_in_range = in_range_r;

  a_shoulder_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |->
      out_theta1 <= $signed({1'b0, shoulder_lim_r}) &&
      out_theta1 >= -$signed({1'b0, shoulder_lim_r}))
    else $error("in_range word has shoulder angle beyond its limit");

  a_elbow_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |->
      out_theta2 <= $signed({1'b0, elbow_lim_r}) &&
      out_theta2 >= -$signed({1'b0, elbow_lim_r}))
    else $error("in_range word has elbow angle beyond its limit");

  a_angle_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_theta1 > -$signed(DEG_HALF) && out_theta1 <= $signed(DEG_HALF) &&
      out_theta2 > -$signed(DEG_HALF) && out_theta2 <= $signed(DEG_HALF))
    else $error("output angle outside the half-open half turn");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_a_r) && $stable(v_p3_r) && $stable(v_d1_r))
    else $error("pipeline valid bits moved during a stall");

endmodule

// ===== src/sik_cordic.sv =====
module sik_cordic
  import sik_pkg::*;
#(
  parameter int ITER = DEF_CORDIC_ITERATIONS,
  parameter int SIDE_W = 1,
  parameter bit ROTATE = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [XW-1:0]    in_x,
  input  logic signed [XW-1:0]    in_y,
  input  logic [AW-1:0]           in_z,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic signed [XW-1:0]    out_x,
  output logic signed [XW-1:0]    out_y,
  output logic [AW-1:0]           out_z,
  output logic [SIDE_W-1:0]       out_side
);

  logic                 v_r    [ITER+1];
  logic signed [XW-1:0] x_r    [ITER+1];
  logic signed [XW-1:0] y_r    [ITER+1];
  logic [AW-1:0]        z_r    [ITER+1];
  logic [SIDE_W-1:0]    side_r [ITER+1];

  logic signed [XW-1:0] x0_nxt, y0_nxt;
  logic [AW-1:0]        z0_nxt;

  // Stage zero folds the vector into the right half plane so the
  // iterations only have to cover a quarter turn either way.
  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    z0_nxt = in_z;
    if (ROTATE) begin
      if ($signed(in_z) > $signed(QUARTER_TURN) ||
          $signed(in_z) < -$signed(QUARTER_TURN)) begin
        x0_nxt = -in_x;
        z0_nxt = in_z ^ HALF_TURN;
      end
    end else if (in_x < 0) begin
      x0_nxt = -in_x;
      y0_nxt = -in_y;
      z0_nxt = in_z + HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 1; i <= ITER; i++) begin : g_iter
    logic signed [XW-1:0] dx, dy, x_nxt, y_nxt;
    logic [AW-1:0]        ang, z_nxt;

    assign dx  = y_r[i-1] >>> (i - 1);
    assign dy  = x_r[i-1] >>> (i - 1);
    assign ang = atan_at(5'(i - 1));

    always_comb begin
      if (ROTATE) begin
        if (!z_r[i-1][AW-1]) begin
          x_nxt = x_r[i-1] - dx;
          y_nxt = y_r[i-1] + dy;
          z_nxt = z_r[i-1] - ang;
        end else begin
          x_nxt = x_r[i-1] + dx;
          y_nxt = y_r[i-1] - dy;
          z_nxt = z_r[i-1] + ang;
        end
      end else begin
        if (!y_r[i-1][XW-1]) begin
          x_nxt = x_r[i-1] + dx;
          y_nxt = y_r[i-1] - dy;
          z_nxt = z_r[i-1] + ang;
        end else begin
          x_nxt = x_r[i-1] - dx;
          y_nxt = y_r[i-1] + dy;
          z_nxt = z_r[i-1] - ang;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = v_r[ITER];
  assign out_x     = x_r[ITER];
  assign out_y     = y_r[ITER];
  assign out_z     = z_r[ITER];
  assign out_side  = side_r[ITER];

endmodule

// ===== tb/tb_scara_inverse_kinematics.sv =====
`timescale 1ns / 100ps

module tb_scara_inverse_kinematics;
  import sik_pkg::*;

  localparam int ITER = DEF_CORDIC_ITERATIONS;
  localparam int CW = DEF_COORD_WIDTH;
  localparam int SCALE_SHIFT = 31 - CW;
  localparam int PIPE_CYCLES = 4 * ITER + 63;

  typedef struct {
    logic signed [ANG_W-1:0] theta1;
    logic signed [ANG_W-1:0] theta2;
    logic                    in_range;
  } joint_sol_t;

  localparam bit [31:0] ATAN_LUT [0:15] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_tool_x = '0;
  logic signed [CW-1:0] in_tool_y = '0;
  logic [1:0] in_arm_select = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ANG_W-1:0] out_theta1;
  logic signed [ANG_W-1:0] out_theta2;
  logic out_in_range;

  bit [13:0] link1_mirror = RST_LINK1;
  bit [13:0] link2_mirror = RST_LINK2;
  bit [13:0] shoulder_mirror = RST_SHOULDER;
  bit [13:0] elbow_mirror = RST_ELBOW;

  joint_sol_t pending_solutions[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  scara_inverse_kinematics dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_tool_x(in_tool_x), .in_tool_y(in_tool_y), .in_arm_select(in_arm_select),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_theta1(out_theta1), .out_theta2(out_theta2), .out_in_range(out_in_range)
  );

  always #4 clk = ~clk;

  // Vectoring rotation: returns the direction of (x0, y0) as a binary angle.
  function automatic bit [31:0] heading(input longint x0, input longint y0,
                                        output longint mag);
    longint x, y, dx, dy;
    bit [31:0] z;
    x = x0;
    y = y0;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic void elbow_point(input longint r, input bit [31:0] a,
                                      output longint ox, output longint oy);
    longint x, y, z, dx, dy;
    int a_s;
    a_s = a;
    x = r;
    y = 0;
    z = a_s;
    if (z > 64'sd1073741824) begin
      x = -x; z -= 64'sd2147483648;
    end else if (z < -64'sd1073741824) begin
      x = -x; z += 64'sd2147483648;
    end
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end else begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic bit [63:0] cos_quotient(input bit [63:0] n, input bit [63:0] d);
    bit [63:0] q, r;
    q = 0;
    r = n;
    if (r >= d) begin
      q = 1; r -= d;
    end
    for (int i = 0; i < 24; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r -= d; q |= 1;
      end
    end
    return q;
  endfunction

  function automatic bit [63:0] floor_sqrt(input bit [63:0] v0);
    bit [63:0] v, r, b;
    v = v0;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Binary angle to 1/64 degree, halves away from zero, -180 shown as +180.
  function automatic longint to_deg64ths(input bit [31:0] a);
    int a_s;
    longint s, q, d;
    bit [63:0] m;
    a_s = a;
    s = a_s;
    m = s < 0 ? -s : s;
    q = (m * 45 + (64'd1 << 22)) >> 23;
    d = s < 0 ? -q : q;
    return d == -11520 ? 11520 : d;
  endfunction

  function automatic joint_sol_t solve_joints(input logic signed [CW-1:0] tx,
                                              input logic signed [CW-1:0] ty,
                                              input logic [1:0] arm);
    joint_sol_t res;
    longint x, y, xs, ys, mag, l1, l2, num, cs, start, px, py, rx, ry, t1, t2, dummy;
    bit [31:0] beta, alpha, a1, phi;
    bit [63:0] lq, n, den, c, s;
    res = '{theta1: '0, theta2: '0, in_range: 1'b0};
    x = tx;
    y = ty;
    if (arm > ARM_RIGHT || (x == 0 && y == 0)) return res;
    xs = x <<< SCALE_SHIFT;
    ys = y <<< SCALE_SHIFT;
    l1 = link1_mirror;
    l2 = link2_mirror;
    beta = heading(xs, ys, mag);
    lq = (64'(mag) * 64'(INV_GAIN)) >> 32;
    num = x * x + y * y + l1 * l1 - l2 * l2;
    n = 64'(num < 0 ? -num : num) << SCALE_SHIFT;
    den = 2 * lq * 64'(l1);
    if (den == 0 || n > den) return res;
    c = cos_quotient(n, den);
    s = floor_sqrt((64'd1 << 48) - c * c);
    cs = num < 0 ? -longint'(c) : longint'(c);
    alpha = heading(cs, longint'(s), dummy);
    a1 = arm == ARM_LEFT ? beta + alpha : beta - alpha;
    start = longint'((64'(l1) * 64'(INV_GAIN)) >> (32 - SCALE_SHIFT));
    elbow_point(start, a1, px, py);
    rx = xs - px;
    ry = ys - py;
    phi = (rx == 0 && ry == 0) ? 32'd0 : heading(rx, ry, dummy);
    t1 = to_deg64ths(a1);
    t2 = to_deg64ths(phi - a1);
    res.theta1 = t1[ANG_W-1:0];
    res.theta2 = t2[ANG_W-1:0];
    res.in_range = ((t1 < 0 ? -t1 : t1) <= shoulder_mirror) &&
                   ((t2 < 0 ? -t2 : t2) <= elbow_mirror);
    return res;
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    joint_sol_t want;
    if (out_valid && out_ready) begin
      if (pending_solutions.size() == 0) begin
        $display("%0t: unexpected word theta1=%0d theta2=%0d in_range=%0d", $time,
                 out_theta1, out_theta2, out_in_range);
        errors++;
      end else begin
        want = pending_solutions.pop_front();
        if (out_theta1 !== want.theta1) begin
          $display("%0t: theta1 expected %0d actual %0d", $time, want.theta1, out_theta1);
          errors++;
        end
        if (out_theta2 !== want.theta2) begin
          $display("%0t: theta2 expected %0d actual %0d", $time, want.theta2, out_theta2);
          errors++;
        end
        if (out_in_range !== want.in_range) begin
          $display("%0t: in_range expected %0d actual %0d", $time, want.in_range,
                   out_in_range);
          errors++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the word was accepted.
  task automatic send_point(input int x, input int y, input int arm);
    joint_sol_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_tool_x <= x[CW-1:0];
    in_tool_y <= y[CW-1:0];
    in_arm_select <= arm[1:0];
    in_valid <= 1'b1;
    want = solve_joints(x[CW-1:0], y[CW-1:0], arm[1:0]);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_solutions.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
  endtask

  // Only called with the pipeline empty. The caller drops the write enable.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_LINK1: link1_mirror = value[13:0];
      CFG_LINK2: link2_mirror = value[13:0];
      CFG_SHOULDER: shoulder_mirror = value[13:0];
      default: elbow_mirror = value[13:0];
    endcase
  endtask

  task automatic set_arm(input int l1, input int l2, input int sh, input int el);
    write_reg(CFG_LINK1, l1);
    write_reg(CFG_LINK2, l2);
    write_reg(CFG_SHOULDER, sh);
    write_reg(CFG_ELBOW, el);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_defaults();
    send_point(0, 0, ARM_LEFT);
    send_point(16383, 16383, ARM_LEFT);
    send_point(-16384, -16384, ARM_RIGHT);
    send_point(-16384, 0, ARM_LEFT);
    send_point(0, -16384, ARM_RIGHT);
    send_point(9600, 0, ARM_LEFT);
    send_point(1600, 0, ARM_RIGHT);
    send_point(200, 0, ARM_LEFT);
    send_point(5000, 3000, ARM_LEFT);
    send_point(5000, 3000, ARM_RIGHT);
    send_point(5000, 3000, 2);
    send_point(5000, 3000, 3);
    send_point(-6000, 2000, ARM_LEFT);
    send_point(0, 9600, ARM_RIGHT);
    send_point(-9000, 0, ARM_LEFT);
    send_point(-9000, -1, ARM_RIGHT);
    send_point(1, 0, ARM_LEFT);
    send_point(-1, -1, ARM_RIGHT);
    drain();
  endtask

  task automatic test_config_extremes();
    // Zero first link makes every point unreachable.
    set_arm(0, 4000, 11520, 11520);
    send_point(4000, 0, ARM_LEFT);
    send_point(-3000, 2000, ARM_RIGHT);
    drain();
    // With no second link the elbow lands on the tool point itself.
    set_arm(5600, 0, 11520, 11520);
    send_point(5600, 0, ARM_LEFT);
    send_point(0, 5600, ARM_RIGHT);
    send_point(-3960, 3960, ARM_LEFT);
    drain();
    set_arm(16383, 16383, 0, 0);
    send_point(16383, 16383, ARM_LEFT);
    send_point(-16384, 5000, ARM_RIGHT);
    send_point(100, 0, ARM_LEFT);
    drain();
  endtask

  task automatic test_random_phase(input int count, input int idle, input int stall);
    int reach, x, y, arm;
    set_arm($urandom_range(16383) % 9000 + 500, $urandom_range(8000),
            $urandom_range(3) == 0 ? 11520 : $urandom_range(11520),
            $urandom_range(3) == 0 ? 11520 : $urandom_range(11520));
    idle_pct = idle;
    stall_pct = stall;
    reach = link1_mirror + link2_mirror;
    if (reach > 16383) reach = 16383;
    if (reach < 1) reach = 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4) == 0) begin
        x = $urandom_range(32767) - 16384;
        y = $urandom_range(32767) - 16384;
      end else begin
        x = $urandom_range(2 * reach) - reach;
        y = $urandom_range(2 * reach) - reach;
      end
      arm = $urandom_range(9) == 0 ? $urandom_range(3, 2) : $urandom_range(1);
      // Runs without idling now and then, so back-to-back words also occur.
      if (i % 100 == 50) idle_pct = 0;
      if (i % 100 == 80) idle_pct = idle;
      send_point(x, y, arm);
    end
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_config_extremes();
    test_random_phase(280, 0, 0);
    test_random_phase(270, 86, 0);
    test_random_phase(270, 0, 86);
    test_random_phase(270, 38, 38);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
